>>> rtl/trilinear_grid_attenuation_unit_macros.svh
// Assertion macros shared by the attenuation unit modules.
`ifndef TRILINEAR_GRID_ATTENUATION_UNIT_MACROS_SVH
`define TRILINEAR_GRID_ATTENUATION_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TGA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TGA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tga_pkg.sv
// Shared types and constants of the trilinear attenuation unit.
package tga_pkg;

	localparam int TGA_LIGHTS    = 4;
	localparam int TGA_GRID_MAX  = 16;
	localparam int TGA_FRAC_BITS = 16;

	localparam int ATT_W = 17;
	localparam logic [ATT_W-1:0] ATT_ONE = 17'h10000;

	typedef enum logic [2:0] {
		REG_BOX_MIN_X = 3'd0,
		REG_BOX_MIN_Y = 3'd1,
		REG_BOX_MIN_Z = 3'd2,
		REG_CPU_X     = 3'd3,
		REG_CPU_Y     = 3'd4,
		REG_CPU_Z     = 3'd5,
		REG_GRID_DIMS = 3'd6
	} tga_reg_t;

	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_QUERY = 1'b1
	} tga_mode_t;

	typedef struct packed {
		tga_mode_t          mode;
		logic [1:0]         light_index;
		logic [11:0]        cell_index;
		logic [16:0]        cell_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} tga_item_t;

	typedef struct packed {
		logic [16:0] attenuation_out;
		logic        inside_res;
	} tga_result_t;

	typedef struct packed {
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic [31:0]        cpu_x;
		logic [31:0]        cpu_y;
		logic [31:0]        cpu_z;
		logic [14:0]        grid_dims;
	} tga_cfg_t;

	// Queue entry: classified item with offsets from the box minimum.
	typedef struct packed {
		logic             is_query;
		logic [1:0]       light_index;
		logic [11:0]      cell_index;
		logic [16:0]      cell_value;
		logic [2:0][31:0] du;   // clamped-to-zero offset per axis, [0] = x
		logic [2:0]       bad;  // negative offset with nonzero scale: outside
	} tga_entry_t;

endpackage

>>> rtl/tga_front.sv
// Front end: accepts items, drops ignored writes, forms box offsets.
module tga_front
	import tga_pkg::*;
#(
	parameter int LIGHTS   = TGA_LIGHTS,
	parameter int GRID_MAX = TGA_GRID_MAX
) (
	input  logic       start,
	input  tga_item_t  item,
	input  tga_cfg_t   cfg,
	input  logic       q_full,
	output logic       busy,
	output logic       push,
	output tga_entry_t entry
);

	localparam int CELLS = GRID_MAX * GRID_MAX * GRID_MAX;

	logic              accept;
	logic              wr_ok;
	logic signed [32:0] d [3];
	logic [31:0]       p [3];
	logic [31:0]       mn [3];
	logic [31:0]       cpu [3];

	assign busy   = q_full;
	assign accept = start & ~q_full;
	assign wr_ok  = (32'(item.light_index) < 32'(LIGHTS)) &&
	                (32'(item.cell_index) < 32'(CELLS));
	assign push   = accept & ((item.mode == MODE_QUERY) | wr_ok);

	always_comb begin
		p[0]   = item.point_x;  p[1]   = item.point_y;  p[2]   = item.point_z;
		mn[0]  = cfg.box_min_x; mn[1]  = cfg.box_min_y; mn[2]  = cfg.box_min_z;
		cpu[0] = cfg.cpu_x;     cpu[1] = cfg.cpu_y;     cpu[2] = cfg.cpu_z;
		entry.is_query    = (item.mode == MODE_QUERY);
		entry.light_index = item.light_index;
		entry.cell_index  = item.cell_index;
		entry.cell_value  = (item.cell_value > ATT_ONE) ? ATT_ONE : item.cell_value;
		for (int a = 0; a < 3; a++) begin
			d[a] = $signed({p[a][31], p[a]}) - $signed({mn[a][31], mn[a]});
			entry.du[a]  = d[a][32] ? 32'd0 : d[a][31:0];
			entry.bad[a] = d[a][32] & (cpu[a] != 32'd0);
		end
	end

endmodule

>>> rtl/tga_queue.sv
// Two-entry queue between the front end and the lookup pipeline.
module tga_queue
	import tga_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tga_entry_t entry_in,
	input  logic       pop,
	output tga_entry_t entry_out,
	output logic       full,
	output logic       empty
);

	`include "trilinear_grid_attenuation_unit_macros.svh"

	tga_entry_t slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign empty     = (cnt_q == 2'd0);
	assign entry_out = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= entry_in;
	end

	`TGA_ASSERT_IMPLIES(a_no_overflow, push && !pop, !full, "queue overflow")
	`TGA_ASSERT_IMPLIES(a_no_underflow, pop, !empty, "queue underflow")
	`TGA_ASSERT_NEXT(a_count_step, push && !pop, cnt_q == $past(cnt_q) + 2'd1,
		"queue count did not follow a push")

endmodule

>>> rtl/tga_back.sv
// Lookup pipeline: cell mapping, replicated grid memory, three lerp stages.
module tga_back
	import tga_pkg::*;
#(
	parameter int LIGHTS    = TGA_LIGHTS,
	parameter int GRID_MAX  = TGA_GRID_MAX,
	parameter int FRAC_BITS = TGA_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tga_cfg_t    cfg,
	input  logic        q_valid,
	input  tga_entry_t  q_entry,
	output logic        pop,
	output logic        res_valid,
	output tga_result_t res
);

	`include "trilinear_grid_attenuation_unit_macros.svh"

	localparam int CELLS = GRID_MAX * GRID_MAX * GRID_MAX;
	localparam int DEPTH = LIGHTS * CELLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = $clog2(GRID_MAX);
	localparam int NW    = $clog2(GRID_MAX + 1);
	localparam int FB    = FRAC_BITS;
	localparam int PW    = 64;
	localparam int CW    = PW - FB;
	localparam logic [FB-1:0] HALF_F = FB'(1) << (FB - 1);

	function automatic logic [NW-1:0] dim_fix(input logic [4:0] f);
		if (f == 5'd0) return NW'(1);
		if (32'(f) > GRID_MAX) return NW'(GRID_MAX);
		return NW'(f);
	endfunction

	// a + ((b - a) * f + 1/2) >> FB, same as the blended form
	function automatic logic [16:0] lerp(input logic [16:0] a, input logic [16:0] b,
	                                     input logic [FB-1:0] f);
		logic signed [17:0]    diff;
		logic signed [FB+18:0] prod;
		logic signed [18:0]    step;
		logic signed [19:0]    sum;
		diff = $signed({1'b0, b}) - $signed({1'b0, a});
		prod = diff * $signed({1'b0, f}) + $signed({1'b0, HALF_F});
		step = 19'(prod >>> FB);
		sum  = $signed({3'b000, a}) + 20'(step);
		return sum[16:0];
	endfunction

	logic [NW-1:0]   n [3];
	logic [31:0]     cpu [3];
	logic [2*NW-1:0] nxy_q;

	assign pop = q_valid;

	always_comb begin
		n[0]   = dim_fix(cfg.grid_dims[4:0]);
		n[1]   = dim_fix(cfg.grid_dims[9:5]);
		n[2]   = dim_fix(cfg.grid_dims[14:10]);
		cpu[0] = cfg.cpu_x;
		cpu[1] = cfg.cpu_y;
		cpu[2] = cfg.cpu_z;
	end

	always_ff @(posedge clk) begin
		nxy_q <= (2*NW)'(n[0]) * (2*NW)'(n[1]);
	end

	// s1: scale offsets into cell units
	logic       v_s1;
	tga_entry_t e_s1;
	logic [PW-1:0] prod_s1 [3];

	always_ff @(posedge clk) begin
		e_s1 <= q_entry;
		for (int a = 0; a < 3; a++)
			prod_s1[a] <= {32'd0, q_entry.du[a]} * {32'd0, cpu[a]};
	end

	// s2: inside test, neighbor indices and fraction per axis
	logic [PW-1:0] lim   [3];
	logic [CW-1:0] c_w   [3];
	logic [CW-1:0] t_w   [3];
	logic [NW-1:0] lo_w  [3];
	logic [NW-1:0] hi_w  [3];
	logic [FB-1:0] fr_w  [3];
	logic [2:0]    in_w;

	logic          v_s2;
	logic          qry_s2;
	logic [1:0]    light_s2;
	logic [11:0]   cell_s2;
	logic [16:0]   val_s2;
	logic [2:0]    in_s2;
	logic [IW-1:0] i0_s2 [3];
	logic [IW-1:0] i1_s2 [3];
	logic [FB-1:0] f_s2  [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lim[a]  = PW'(n[a]) << (2 * FB);
			in_w[a] = ~e_s1.bad[a] && (prod_s1[a] <= lim[a]);
			c_w[a]  = prod_s1[a][PW-1:FB];
			t_w[a]  = c_w[a] - (CW'(1) << (FB - 1));
			if (c_w[a] < (CW'(1) << (FB - 1))) begin
				lo_w[a] = '0;
				hi_w[a] = '0;
				fr_w[a] = '0;
			end else begin
				lo_w[a] = t_w[a][FB+NW-1:FB];
				fr_w[a] = t_w[a][FB-1:0];
				hi_w[a] = (fr_w[a] != '0) ? lo_w[a] + NW'(1) : lo_w[a];
				if (hi_w[a] > n[a] - NW'(1)) hi_w[a] = n[a] - NW'(1);
				if (lo_w[a] > n[a] - NW'(1)) lo_w[a] = n[a] - NW'(1);
				if (lo_w[a] == hi_w[a]) fr_w[a] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		qry_s2   <= e_s1.is_query;
		light_s2 <= e_s1.light_index;
		cell_s2  <= e_s1.cell_index;
		val_s2   <= e_s1.cell_value;
		in_s2    <= in_w;
		for (int a = 0; a < 3; a++) begin
			i0_s2[a] <= lo_w[a][IW-1:0];
			i1_s2[a] <= hi_w[a][IW-1:0];
			f_s2[a]  <= fr_w[a];
		end
	end

	// s3: corner addresses, corner k = {x1 sel, y1 sel, z1 sel}
	logic [31:0]   base_w;
	logic [AW-1:0] raddr_w [8];

	logic          qv_s3;
	logic          we_s3;
	logic [AW-1:0] waddr_s3;
	logic [16:0]   wdata_s3;
	logic [AW-1:0] raddr_s3 [8];
	logic          ok_s3;
	logic          in_s3;
	logic [FB-1:0] f_s3 [3];

	always_comb begin
		base_w = 32'(light_s2) * 32'(CELLS);
		for (int k = 0; k < 8; k++) begin
			raddr_w[k] = AW'(base_w
				+ 32'(k[2] ? i1_s2[0] : i0_s2[0])
				+ 32'(k[1] ? i1_s2[1] : i0_s2[1]) * 32'(n[0])
				+ 32'(k[0] ? i1_s2[2] : i0_s2[2]) * 32'(nxy_q));
		end
	end

	always_ff @(posedge clk) begin
		waddr_s3 <= AW'(base_w + 32'(cell_s2));
		wdata_s3 <= val_s2;
		raddr_s3 <= raddr_w;
		ok_s3    <= (&in_s2) && (32'(light_s2) < 32'(LIGHTS));
		in_s3    <= &in_s2;
		f_s3     <= f_s2;
	end

	// s4: eight identical copies of the grid, one read port each
	logic [16:0]   rd_s4 [8];
	logic          qv_s4;
	logic          ok_s4;
	logic          in_s4;
	logic [FB-1:0] f_s4 [3];

	for (genvar k = 0; k < 8; k++) begin : g_bank
		logic [16:0] mem [DEPTH];
		always_ff @(posedge clk) begin
			if (we_s3) mem[waddr_s3] <= wdata_s3;
			rd_s4[k] <= mem[raddr_s3[k]];
		end
	end

	always_ff @(posedge clk) begin
		ok_s4 <= ok_s3;
		in_s4 <= in_s3;
		f_s4  <= f_s3;
	end

	// s5: blend along z
	logic          qv_s5;
	logic [16:0]   zl_s5 [4];
	logic          ok_s5;
	logic          in_s5;
	logic [FB-1:0] fy_s5;
	logic [FB-1:0] fx_s5;

	always_ff @(posedge clk) begin
		for (int m = 0; m < 4; m++)
			zl_s5[m] <= lerp(rd_s4[2*m], rd_s4[2*m+1], f_s4[2]);
		ok_s5 <= ok_s4;
		in_s5 <= in_s4;
		fy_s5 <= f_s4[1];
		fx_s5 <= f_s4[0];
	end

	// s6: blend along y
	logic          qv_s6;
	logic [16:0]   yl_s6 [2];
	logic          ok_s6;
	logic          in_s6;
	logic [FB-1:0] fx_s6;

	always_ff @(posedge clk) begin
		yl_s6[0] <= lerp(zl_s5[0], zl_s5[1], fy_s5);
		yl_s6[1] <= lerp(zl_s5[2], zl_s5[3], fy_s5);
		ok_s6    <= ok_s5;
		in_s6    <= in_s5;
		fx_s6    <= fx_s5;
	end

	// output register: blend along x
	logic [16:0] att_w;
	logic        res_valid_q;
	tga_result_t res_q;

	assign att_w = lerp(yl_s6[0], yl_s6[1], fx_s6);

	always_ff @(posedge clk) begin
		res_q.attenuation_out <= !ok_s6 ? 17'd0 : (att_w > ATT_ONE) ? ATT_ONE : att_w;
		res_q.inside_res      <= in_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			qv_s3       <= 1'b0;
			we_s3       <= 1'b0;
			qv_s4       <= 1'b0;
			qv_s5       <= 1'b0;
			qv_s6       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			qv_s3       <= v_s2 & qry_s2;
			we_s3       <= v_s2 & ~qry_s2;
			qv_s4       <= qv_s3;
			qv_s5       <= qv_s4;
			qv_s6       <= qv_s5;
			res_valid_q <= qv_s6;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`TGA_ASSERT_NEXT(a_res_from_query, qv_s6, res_valid, "query lost before output")
	`TGA_ASSERT_IMPLIES(a_outside_zero, res_valid && !res.inside_res,
		res.attenuation_out == 17'd0, "nonzero attenuation outside box")
	`TGA_ASSERT_IMPLIES(a_wr_rd_excl, we_s3, !qv_s3, "write and query share a stage")

endmodule

>>> rtl/trilinear_grid_attenuation_unit.sv
// Top level of the trilinear grid attenuation unit.
//
//  channel   ports                                  transfer when
//  item      start, busy, item                      start && !busy
//  result    res_valid, res                         res_valid (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data   cfg_valid && cfg_ready
//
// One item per cycle while busy is low; each query yields one result strobe.
// Each corner of the 8-cell blend reads its own copy of the grid memory,
// so one query per cycle is set by the single read port of each copy.
// Writes take the same pipeline and produce no result.
// Reset clears control and sets config defaults; grid is undefined until written.
module trilinear_grid_attenuation_unit
	import tga_pkg::*;
#(
	parameter int LIGHTS    = TGA_LIGHTS,
	parameter int GRID_MAX  = TGA_GRID_MAX,
	parameter int FRAC_BITS = TGA_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  tga_item_t   item,
	output logic        res_valid,
	output tga_result_t res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	tga_cfg_t   cfg_q;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;
	tga_entry_t f_entry;
	tga_entry_t q_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_min_x <= '0;
			cfg_q.box_min_y <= '0;
			cfg_q.box_min_z <= '0;
			cfg_q.cpu_x     <= 32'd65536;
			cfg_q.cpu_y     <= 32'd65536;
			cfg_q.cpu_z     <= 32'd65536;
			cfg_q.grid_dims <= 15'd16912;
		end else if (cfg_valid && cfg_ready) begin
			case (tga_reg_t'(cfg_index))
				REG_BOX_MIN_X: cfg_q.box_min_x <= cfg_data;
				REG_BOX_MIN_Y: cfg_q.box_min_y <= cfg_data;
				REG_BOX_MIN_Z: cfg_q.box_min_z <= cfg_data;
				REG_CPU_X:     cfg_q.cpu_x     <= cfg_data;
				REG_CPU_Y:     cfg_q.cpu_y     <= cfg_data;
				REG_CPU_Z:     cfg_q.cpu_z     <= cfg_data;
				REG_GRID_DIMS: cfg_q.grid_dims <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	tga_front #(
		.LIGHTS   (LIGHTS),
		.GRID_MAX (GRID_MAX)
	) u_front (
		.start  (start),
		.item   (item),
		.cfg    (cfg_q),
		.q_full (q_full),
		.busy   (busy),
		.push   (push),
		.entry  (f_entry)
	);

	tga_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.entry_in  (f_entry),
		.pop       (pop),
		.entry_out (q_entry),
		.full      (q_full),
		.empty     (q_empty)
	);

	tga_back #(
		.LIGHTS    (LIGHTS),
		.GRID_MAX  (GRID_MAX),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (!q_empty),
		.q_entry   (q_entry),
		.pop       (pop),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

>>> sim/trilinear_grid_attenuation_unit_tb.sv
// Self-checking testbench of the trilinear grid attenuation unit: grid loads and point queries.
module trilinear_grid_attenuation_unit_tb;
	import tga_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		bit              ok;
		int unsigned     lo;
		int unsigned     hi;
		longint unsigned fr;
	} axis_map_t;

	localparam int CELLS = TGA_GRID_MAX * TGA_GRID_MAX * TGA_GRID_MAX;
	localparam int DRAIN_CYCLES = 12;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	tga_item_t   item;
	logic        res_valid;
	tga_result_t res;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	logic [31:0] cfg_shadow [7];
	logic [16:0] grid_shadow [TGA_LIGHTS][CELLS];
	bit          cell_loaded [TGA_LIGHTS][CELLS];
	tga_result_t att_expected [$];

	int errors;
	int n_queries;
	int n_loads;
	int n_inside;
	int n_cfg;
	int n_sent;
	int gap_pct;

	trilinear_grid_attenuation_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.res_valid(res_valid), .res(res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int unsigned grid_dim(int sh);
		int unsigned n;
		n = (cfg_shadow[REG_GRID_DIMS] >> sh) & 31;
		if (n < 1) n = 1;
		if (n > TGA_GRID_MAX) n = TGA_GRID_MAX;
		return n;
	endfunction

	function automatic axis_map_t map_coord(logic [31:0] p, logic [31:0] mn,
			logic [31:0] cpu, int unsigned n);
		axis_map_t r;
		longint d;
		longint unsigned du, lim, c, t, fr, half, scale;
		int unsigned a, b;
		r = '{0, 0, 0, 0};
		half = 64'd1 << (TGA_FRAC_BITS - 1);
		scale = {32'd0, cpu};
		d = longint'($signed(p)) - longint'($signed(mn));
		if (d < 0) begin
			if (scale != 0) return r;
			d = 0;
		end
		du = d;
		lim = longint'(n) << (2 * TGA_FRAC_BITS);
		if (scale != 0 && du > lim / scale) return r;
		r.ok = 1;
		c = (du * scale) >> TGA_FRAC_BITS;
		if (c < half) return r;
		t = c - half;
		a = t >> TGA_FRAC_BITS;
		fr = t & ((64'd1 << TGA_FRAC_BITS) - 1);
		b = (fr != 0) ? a + 1 : a;
		if (b > n - 1) b = n - 1;
		if (a > n - 1) a = n - 1;
		r.lo = a;
		r.hi = b;
		r.fr = (a != b) ? fr : 0;
		return r;
	endfunction

	function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
			longint unsigned f);
		longint unsigned one;
		one = 64'd1 << TGA_FRAC_BITS;
		return (a * (one - f) + b * f + (one >> 1)) >> TGA_FRAC_BITS;
	endfunction

	// corner k: bit 0 picks x1, bit 1 y1, bit 2 z1
	function automatic int unsigned corner_addr(axis_map_t mx, axis_map_t my,
			axis_map_t mz, int k);
		int unsigned nx, ny;
		nx = grid_dim(0);
		ny = grid_dim(5);
		return (k[0] ? mx.hi : mx.lo) + (k[1] ? my.hi : my.lo) * nx
			+ (k[2] ? mz.hi : mz.lo) * nx * ny;
	endfunction

	// Update the shadow state for one accepted item.
	task automatic apply_item(tga_item_t it);
		axis_map_t mx, my, mz;
		longint unsigned v [8];
		longint unsigned att;
		tga_result_t r;
		if (it.mode == MODE_WRITE) begin
			n_loads++;
			if (it.light_index < TGA_LIGHTS) begin
				grid_shadow[it.light_index][it.cell_index] =
					(it.cell_value > ATT_ONE) ? ATT_ONE : it.cell_value;
				cell_loaded[it.light_index][it.cell_index] = 1;
			end
			return;
		end
		n_queries++;
		mx = map_coord(it.point_x, cfg_shadow[REG_BOX_MIN_X], cfg_shadow[REG_CPU_X], grid_dim(0));
		my = map_coord(it.point_y, cfg_shadow[REG_BOX_MIN_Y], cfg_shadow[REG_CPU_Y], grid_dim(5));
		mz = map_coord(it.point_z, cfg_shadow[REG_BOX_MIN_Z], cfg_shadow[REG_CPU_Z], grid_dim(10));
		r = '0;
		if (mx.ok && my.ok && mz.ok) begin
			n_inside++;
			r.inside_res = 1'b1;
			if (it.light_index < TGA_LIGHTS) begin
				for (int k = 0; k < 8; k++)
					v[k] = grid_shadow[it.light_index][corner_addr(mx, my, mz, k)];
				att = blend(blend(blend(v[0], v[4], mz.fr), blend(v[2], v[6], mz.fr), my.fr),
					blend(blend(v[1], v[5], mz.fr), blend(v[3], v[7], mz.fr), my.fr), mx.fr);
				if (att > ATT_ONE) att = ATT_ONE;
				r.attenuation_out = att[16:0];
			end
		end
		att_expected.push_back(r);
	endtask

	task automatic send_item(tga_item_t it);
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		apply_item(it);
		n_sent++;
	endtask

	task automatic idle_cycles(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic maybe_gap();
		if ($urandom_range(99) < gap_pct) idle_cycles($urandom_range(1, 4));
	endtask

	task automatic load_cell(logic [1:0] light, logic [11:0] cell_idx, logic [16:0] value);
		tga_item_t it;
		it = '0;
		it.mode = MODE_WRITE;
		it.light_index = light;
		it.cell_index = cell_idx;
		it.cell_value = value;
		it.point_x = $urandom;
		it.point_y = $urandom;
		it.point_z = $urandom;
		send_item(it);
	endtask

	// Loads any corner the query would read that was never written, then sends the query.
	task automatic query_point(logic [1:0] light, logic [31:0] px, logic [31:0] py,
			logic [31:0] pz);
		tga_item_t it;
		axis_map_t mx, my, mz;
		int unsigned a;
		mx = map_coord(px, cfg_shadow[REG_BOX_MIN_X], cfg_shadow[REG_CPU_X], grid_dim(0));
		my = map_coord(py, cfg_shadow[REG_BOX_MIN_Y], cfg_shadow[REG_CPU_Y], grid_dim(5));
		mz = map_coord(pz, cfg_shadow[REG_BOX_MIN_Z], cfg_shadow[REG_CPU_Z], grid_dim(10));
		if (mx.ok && my.ok && mz.ok)
			for (int k = 0; k < 8; k++) begin
				a = corner_addr(mx, my, mz, k);
				if (!cell_loaded[light][a]) begin
					load_cell(light, 12'(a), 17'($urandom_range(0, 17'h1FFFF)));
					maybe_gap();
				end
			end
		it = '0;
		it.mode = MODE_QUERY;
		it.light_index = light;
		it.cell_index = 12'($urandom);
		it.cell_value = 17'($urandom);
		it.point_x = px;
		it.point_y = py;
		it.point_z = pz;
		send_item(it);
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		while (att_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// valid stays high across back-to-back writes; set_box drops it after the last one
	task automatic set_reg(tga_reg_t r, logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_shadow[r] = (r == REG_GRID_DIMS) ? {17'd0, v[14:0]} : v;
		n_cfg++;
	endtask

	task automatic set_box(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
			logic [31:0] cx, logic [31:0] cy, logic [31:0] cz, logic [14:0] dims);
		wait_drain();
		set_reg(REG_BOX_MIN_X, mx);
		set_reg(REG_BOX_MIN_Y, my);
		set_reg(REG_BOX_MIN_Z, mz);
		set_reg(REG_CPU_X, cx);
		set_reg(REG_CPU_Y, cy);
		set_reg(REG_CPU_Z, cz);
		set_reg(REG_GRID_DIMS, dims);
		cfg_valid <= 1'b0;
	endtask

	// Point on one axis, mostly inside the box, with some margin beyond each face.
	function automatic logic [31:0] pick_coord(logic [31:0] mn, logic [31:0] cpu,
			int unsigned n);
		longint t;
		longint d;
		if ($urandom_range(9) == 0) return $urandom;
		t = longint'($urandom_range(0, n * 65536 + 4000)) - 2000;
		if ($urandom_range(7) == 0) t = (t < 0) ? 0 : longint'(n) * 65536;
		if (cpu == 0) d = t;
		else d = (t <<< 16) / longint'({32'd0, cpu});
		return mn + d[31:0];
	endfunction

	task automatic test_reset_defaults();
		query_point(0, 32'h0, 32'h0, 32'h0);
		query_point(1, 32'h0008_8000, 32'h0003_4000, 32'h000F_C000);
		query_point(3, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000);
		query_point(2, 32'h0010_0001, 32'h0, 32'h0);
		query_point(2, 32'hFFFF_FFFF, 32'h0, 32'h0);
	endtask

	task automatic test_edges();
		// small 2x3x4 grid, box starting at -1.0
		set_box(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 15'd4 << 10 | 15'd3 << 5 | 15'd2);
		load_cell(0, 0, 17'h1FFFF);
		load_cell(0, 1, 17'h0);
		load_cell(0, 2, ATT_ONE);
		query_point(0, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
		query_point(0, 32'h0000_0000, 32'h0000_8000, 32'h0000_8000);
		query_point(0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
		query_point(0, 32'h0001_0001, 32'h0, 32'h0);
		query_point(0, 32'hFFFE_FFFF, 32'h0, 32'h0);
		// zero scale on x, dims of zero and above the maximum
		set_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF,
			15'd0 << 10 | 15'd31 << 5 | 15'd0);
		query_point(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		query_point(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
		query_point(1, 32'h0, 32'h0, 32'h0000_0002);
		query_point(1, 32'h0, 32'h0, 32'hFFFF_FFFF);
		set_box(32'h0, 32'h0, 32'h0, 32'h0002_0000, 32'h0000_8000, 32'h0001_8000,
			15'h7FFF);
		query_point(2, 32'h0001_2345, 32'h0007_FFFF, 32'h000A_AAAA);
		query_point(3, 32'h0007_FFFF, 32'h0020_0000, 32'h0);
		query_point(3, 32'h0008_0000, 32'h0020_0001, 32'h0);
	endtask

	// items counts every transfer, corner loads ahead of queries included
	task automatic test_random_traffic(int items);
		logic [1:0] lt;
		logic [14:0] dims;
		logic [31:0] mn [3];
		logic [31:0] cpu [3];
		int base;
		base = n_sent;
		while (n_sent - base < items) begin
			dims = 0;
			for (int a = 0; a < 3; a++) begin
				case ($urandom_range(19))
					0: dims |= 15'($urandom_range(0, 31)) << (5 * a);
					1: dims |= 15'(16) << (5 * a);
					default: dims |= 15'($urandom_range(1, 4)) << (5 * a);
				endcase
				mn[a] = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 32'h0020_0000)
					- 32'h0010_0000;
				case ($urandom_range(11))
					0: cpu[a] = 0;
					1: cpu[a] = $urandom;
					default: cpu[a] = $urandom_range(32'h4000, 32'h40000);
				endcase
			end
			set_box(mn[0], mn[1], mn[2], cpu[0], cpu[1], cpu[2], dims);
			for (int k = 0; k < 60 && n_sent - base < items; k++) begin
				lt = 2'($urandom_range(0, 3));
				if ($urandom_range(4) == 0)
					load_cell(lt, 12'($urandom_range(0, CELLS - 1)),
						17'($urandom_range(0, 17'h1FFFF)));
				else
					query_point(lt, pick_coord(mn[0], cpu[0], grid_dim(0)),
						pick_coord(mn[1], cpu[1], grid_dim(5)),
						pick_coord(mn[2], cpu[2], grid_dim(10)));
				if (k == 30 && $urandom_range(3) == 0) wait_drain();
				maybe_gap();
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid) begin
			if (att_expected.size() == 0) begin
				$display("%0t: unexpected result att=%h inside=%b", $time,
					res.attenuation_out, res.inside_res);
				errors++;
			end else begin
				if (res.attenuation_out !== att_expected[0].attenuation_out) begin
					$display("%0t: attenuation expected %h actual %h", $time,
						att_expected[0].attenuation_out, res.attenuation_out);
					errors++;
				end
				if (res.inside_res !== att_expected[0].inside_res) begin
					$display("%0t: inside flag expected %b actual %b", $time,
						att_expected[0].inside_res, res.inside_res);
					errors++;
				end
				void'(att_expected.pop_front());
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cfg_shadow[REG_BOX_MIN_X] = 0;
		cfg_shadow[REG_BOX_MIN_Y] = 0;
		cfg_shadow[REG_BOX_MIN_Z] = 0;
		cfg_shadow[REG_CPU_X] = 32'h0001_0000;
		cfg_shadow[REG_CPU_Y] = 32'h0001_0000;
		cfg_shadow[REG_CPU_Z] = 32'h0001_0000;
		cfg_shadow[REG_GRID_DIMS] = 16912;
		gap_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_edges();
		gap_pct = 25;
		test_random_traffic(430);
		gap_pct = 71;
		test_random_traffic(430);
		gap_pct = 0;
		test_random_traffic(430);
		wait_drain();
		$display("covered %0d queries (%0d inside), %0d cell loads, %0d register writes",
			n_queries, n_inside, n_loads, n_cfg);
		$display("with sender gaps at 25, 71 and 0 percent; %0d mismatches", errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
